// File: rtl/utt_pkg.sv
// Shared types, constants and the UTF-8 byte encoder of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps

package utt_pkg;

   localparam logic [5:0]  HIGH_SURR_TAG  = 6'b110110;
   localparam logic [5:0]  LOW_SURR_TAG   = 6'b110111;
   localparam logic [20:0] SUPPLEMENT_BASE = 21'h10000;
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_PAIR  = 2'd1,
      STATUS_STRAY_LOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } len_type;

   typedef struct packed {
      logic [20:0] code_point;
      len_type     len;
      status_type  status;
      logic        last;
   } job_type;

   function automatic logic [7:0] utt_utf8_byte(logic [20:0] cp, len_type len,
                                                logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      unique case ({len, idx})
         {LEN_ONE,   2'd0}: b = {1'b0, cp[6:0]};
         {LEN_TWO,   2'd0}: b = {3'b110, cp[10:6]};
         {LEN_TWO,   2'd1}: b = {2'b10, cp[5:0]};
         {LEN_THREE, 2'd0}: b = {4'b1110, cp[15:12]};
         {LEN_THREE, 2'd1}: b = {2'b10, cp[11:6]};
         {LEN_THREE, 2'd2}: b = {2'b10, cp[5:0]};
         {LEN_FOUR,  2'd0}: b = {5'b11110, cp[20:18]};
         {LEN_FOUR,  2'd1}: b = {2'b10, cp[17:12]};
         {LEN_FOUR,  2'd2}: b = {2'b10, cp[11:6]};
         {LEN_FOUR,  2'd3}: b = {2'b10, cp[5:0]};
         default:           b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/utf16_to_utf8_transcoder_unit.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and byte emitter.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         req_push/req_full  req_code_unit[15:0], req_last_unit
//   rsp_      out        rsp_pop/rsp_empty  rsp_out_byte[7:0], rsp_run_end,
//                                           rsp_string_end, rsp_status[1:0]
//
// An item is taken every cycle while the job queue has room; the emitter sends a code point
// of n bytes one byte at a time, and new items queue while an earlier one is being sent.
// The first byte of an item passes through the job queue and then the result register.
// Reset is synchronous and clears the surrogate, drop and queue state.
// A stalled result holds the emitter, and the queue of QUEUE_DEPTH jobs then fills
// before req_full rises.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_unit
   import utt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_end,
   output logic        rsp_string_end,
   output logic [1:0]  rsp_status
);

   logic    queue_full;
   logic    queue_push;
   job_type push_job;
   logic    queue_pop;
   logic    queue_empty;
   job_type head_job;

   utt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_job     (push_job)
   );

   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   utt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_job      (head_job),
      .queue_pop      (queue_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_string_end (rsp_string_end),
      .rsp_status     (rsp_status)
   );

endmodule

// File: rtl/utt_front.sv
// Front end: accepts code units, pairs surrogates, tracks dropped strings and queues jobs.
`timescale 1ns / 1ps

module utt_front
   import utt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   input  logic        queue_full,
   output logic        queue_push,
   output job_type     queue_job
);

   logic [9:0] held_high_ff, held_high_in;
   logic       held_valid_ff, held_valid_in;
   logic       dropping_ff, dropping_in;
   logic       accept;
   logic       is_high;
   logic       is_low;
   len_type    bmp_len;

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;
   assign is_high  = req_code_unit[15:10] == HIGH_SURR_TAG;
   assign is_low   = req_code_unit[15:10] == LOW_SURR_TAG;

   always_comb begin
      if (req_code_unit < ONE_BYTE_LIMIT) begin
         bmp_len = LEN_ONE;
      end else if (req_code_unit < TWO_BYTE_LIMIT) begin
         bmp_len = LEN_TWO;
      end else begin
         bmp_len = LEN_THREE;
      end
   end

   always_comb begin
      held_high_in         = held_high_ff;
      held_valid_in        = held_valid_ff;
      dropping_in          = dropping_ff;
      queue_push           = 1'b0;
      queue_job.code_point = {5'd0, req_code_unit};
      queue_job.len        = bmp_len;
      queue_job.status     = STATUS_OK;
      queue_job.last       = req_last_unit;
      if (accept) begin
         if (dropping_ff) begin
            dropping_in = !req_last_unit;
         end else if (held_valid_ff) begin
            held_valid_in = 1'b0;
            held_high_in  = 10'd0;
            queue_push    = 1'b1;
            if (is_low) begin
               queue_job.code_point = SUPPLEMENT_BASE +
                                      {1'b0, held_high_ff, req_code_unit[9:0]};
               queue_job.len        = LEN_FOUR;
            end else begin
               queue_job.len    = LEN_ONE;
               queue_job.status = STATUS_BAD_PAIR;
               dropping_in      = !req_last_unit;
            end
         end else if (is_high) begin
            if (req_last_unit) begin
               queue_push       = 1'b1;
               queue_job.len    = LEN_ONE;
               queue_job.status = STATUS_BAD_PAIR;
            end else begin
               held_valid_in = 1'b1;
               held_high_in  = req_code_unit[9:0];
            end
         end else if (is_low) begin
            queue_push       = 1'b1;
            queue_job.len    = LEN_ONE;
            queue_job.status = STATUS_STRAY_LOW;
            dropping_in      = !req_last_unit;
         end else begin
            queue_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_high_ff  <= 10'd0;
         held_valid_ff <= 1'b0;
         dropping_ff   <= 1'b0;
      end else begin
         held_high_ff  <= held_high_in;
         held_valid_ff <= held_valid_in;
         dropping_ff   <= dropping_in;
      end
   end

   // A held high surrogate and a dropped string never coexist.
   assert property (@(posedge clock) disable iff (reset) !(held_valid_ff && dropping_ff))
      else $error("held surrogate while dropping");
   // A queued supplementary code point always comes from a held high surrogate.
   assert property (@(posedge clock) disable iff (reset)
      queue_push && queue_job.len == LEN_FOUR |-> held_valid_ff)
      else $error("four byte job without held surrogate");
   // Nothing is queued for an item that falls in a dropped string.
   assert property (@(posedge clock) disable iff (reset) dropping_ff |-> !queue_push)
      else $error("job queued while dropping");

endmodule

// File: rtl/utt_queue.sv
// Small job queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module utt_queue
   import utt_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type           entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = count_ff == CntW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The fill count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(DEPTH))
      else $error("queue overfilled");
   // Equal pointers mean the queue is either empty or full.
   assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == rd_ptr_ff |-> empty || full)
      else $error("queue pointers disagree with count");
   // A push on a full queue without a pop leaves the count unchanged.
   assert property (@(posedge clock) disable iff (reset)
      full && push && !pop |=> full)
      else $error("queue count moved on a rejected push");

endmodule

// File: rtl/utt_back.sv
// Back end: walks each queued job one UTF-8 byte per cycle into the result register while the result is not stalled.
`timescale 1ns / 1ps

module utt_back
   import utt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  job_type    queue_job,
   output logic       queue_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end,
   output logic [1:0] rsp_status
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   logic       run_end_ff;
   logic       string_end_ff;
   status_type status_ff;
   logic       load;
   logic       final_byte;
   logic [7:0] next_byte;

   assign load       = !queue_empty && (!out_valid_ff || rsp_pop);
   assign final_byte = idx_ff == queue_job.len;
   assign queue_pop  = load && final_byte;
   assign next_byte  = (queue_job.status == STATUS_OK) ?
                       utt_utf8_byte(queue_job.code_point, queue_job.len, idx_ff) : 8'h00;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         idx_in       = final_byte ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff       <= next_byte;
         run_end_ff    <= final_byte;
         string_end_ff <= final_byte && queue_job.last;
         status_ff     <= queue_job.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_string_end = string_end_ff;
   assign rsp_status     = status_ff;

   // An error item is a single zero byte that closes its run.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && status_ff != STATUS_OK |-> byte_ff == 8'h00 && run_end_ff)
      else $error("malformed error item");
   // The end of a string is always the end of a run.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && string_end_ff |-> run_end_ff)
      else $error("string end inside a run");
   // The byte index stays within the length of the job at the head.
   assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> idx_ff <= queue_job.len)
      else $error("byte index past job length");

endmodule
